// ===== rtl/euc_to_sjis_name_builder_macros.svh =====
// euc_to_sjis_name_builder_macros.svh: assertion macros for the name builder
// no dependencies; included by files that carry concurrent checks
`ifndef EUC_TO_SJIS_NAME_BUILDER_MACROS_SVH
`define EUC_TO_SJIS_NAME_BUILDER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ETS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("name builder check failed");

// next-cycle implication, checked out of reset
`define ETS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("name builder check failed");

`endif

// ===== rtl/ets_pkg.sv =====
// ets_pkg: shared types and constants of the euc to shift-jis name builder
// no dependencies; used by ets_conv, ets_ctrl and the top level
package ets_pkg;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_MAIN  = 2'd1,
        FN_SUB   = 2'd2,
        FN_FIN   = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic       main_present;
        logic [7:0] code_high;
        logic [7:0] code_low;
    } item_t;

    typedef struct packed {
        logic       fire;
        logic       emit;
        logic       done;
        logic [7:0] out_high;
        logic [7:0] out_low;
        logic [4:0] slot;
        logic       last;
    } step_t;

    localparam logic [7:0] DOT_HIGH = 8'h81;
    localparam logic [7:0] DOT_LOW  = 8'h45;

    localparam logic [7:0] EUC_OFS      = 8'd128;
    localparam logic [7:0] LOW_ODD_ADD  = 8'd31;
    localparam logic [7:0] LOW_EVEN_ADD = 8'd125;
    localparam logic [7:0] HI_ODD_ADD   = 8'd113;
    localparam logic [7:0] HI_EVEN_ADD  = 8'd112;
    localparam logic [7:0] HI_GAP_START = 8'd160;
    localparam logic [7:0] HI_GAP_ADD   = 8'd64;
    localparam logic [7:0] LOW_GAP      = 8'd127;
    localparam logic [7:0] CIRC_HIGH    = 8'd135;
    localparam logic [7:0] CIRC_LOW     = 8'd84;
    localparam logic [7:0] ALT_HIGH     = 8'd130;
    localparam logic [7:0] ALT_LOW      = 8'd80;

endpackage

// ===== rtl/euc_to_sjis_name_builder.sv =====
// path: an accepted word is held in the input word register; its results go out on m_
//   from the single result register. throughput: 1 word per cycle for start, main and
//   plain sub words while the result register is free; a sub word that also places the
//   middle dot emits the dot first; finish emits pad pairs (up to RECORD_PAIRS)
// reset: aresetn synchronous active low; clears record state and both valid flags
// depends on ets_pkg, ets_ctrl, ets_conv and euc_to_sjis_name_builder_macros.svh
`include "euc_to_sjis_name_builder_macros.svh"

module euc_to_sjis_name_builder #(
    parameter int MAX_CHARS    = 16,
    parameter int RECORD_PAIRS = 17
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // main_present[0], code_high[8:1], code_low[16:9], zero
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_high[7:0], out_low[15:8], slot[20:16], zero
    output logic        m_tlast    // last pad pair of the record
);
    import ets_pkg::*;

    localparam int PCW = $clog2(RECORD_PAIRS + 1);

    // input word register
    logic  item_valid_reg, item_valid_next;
    item_t item_reg;
    item_t s_item;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_high_reg;
    logic [7:0]  m_low_reg;
    logic [4:0]  m_slot_reg;
    logic        m_last_reg;

    step_t          step;
    logic [PCW-1:0] pair_cnt;
    logic           out_free;
    logic           s_take;
    logic           item_retire;

    assign s_item.func         = func_t'(s_tuser);
    assign s_item.main_present = s_tdata[0];
    assign s_item.code_high    = s_tdata[8:1];
    assign s_item.code_low     = s_tdata[16:9];

    // the result register frees up when empty or when its word is taken
    assign out_free    = !m_valid_reg || m_tready;
    // held word finishes its last step this cycle
    assign item_retire = step.fire && step.done;
    // the next word may enter as the held one retires
    assign s_tready    = !item_valid_reg || item_retire;
    assign s_take      = s_tvalid && s_tready;

    ets_ctrl #(
        .MAX_CHARS    (MAX_CHARS),
        .RECORD_PAIRS (RECORD_PAIRS),
        .PCW          (PCW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .out_free   (out_free),
        .step       (step),
        .pair_cnt   (pair_cnt)
    );

    always_comb begin
        item_valid_next = item_valid_reg;
        if (s_take) begin
            item_valid_next = 1'b1;
        end else if (item_retire) begin
            item_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (step.fire && step.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg <= s_item;
        end
        if (step.fire && step.emit) begin
            m_high_reg <= step.out_high;
            m_low_reg  <= step.out_low;
            m_slot_reg <= step.slot;
            m_last_reg <= step.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_slot_reg, m_low_reg, m_high_reg};
    assign m_tlast  = m_last_reg;

    // an empty input register always takes a word
    `ETS_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !item_valid_reg, s_tready)
    // the pair count never runs past the record length
    `ETS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, pair_cnt <= PCW'(RECORD_PAIRS))
    // the marked pair sits in the final slot of the record
    `ETS_ASSERT_NOW(a_last_slot, aclk, aresetn, m_tvalid && m_tlast,
        m_tdata[20:16] == 5'(RECORD_PAIRS - 1))
    // a pad pair that closes the record leaves the count cleared
    `ETS_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, step.fire && step.emit && step.last,
        pair_cnt == '0)

endmodule

// ===== rtl/ets_conv.sv =====
// ets_conv: combinational euc-jp to shift-jis pair conversion, 8-bit wrap
// depends on ets_pkg
module ets_conv (
    input  logic [7:0] euc_high,
    input  logic [7:0] euc_low,
    output logic [7:0] sjis_high,
    output logic [7:0] sjis_low
);
    import ets_pkg::*;

    logic [7:0] a0;
    logic [7:0] b0;
    logic [7:0] a1;
    logic [7:0] b1;
    logic [7:0] a2;
    logic [7:0] b2;

    always_comb begin
        a0 = euc_high + EUC_OFS;
        b0 = euc_low + EUC_OFS;
        if (a0[0]) begin
            b1 = b0 + LOW_ODD_ADD;
            a1 = {1'b0, a0[7:1]} + HI_ODD_ADD;
        end else begin
            b1 = b0 + LOW_EVEN_ADD;
            a1 = {1'b0, a0[7:1]} + HI_EVEN_ADD;
        end
        a2 = (a1 >= HI_GAP_START) ? a1 + HI_GAP_ADD : a1;
        b2 = (b1 >= LOW_GAP) ? b1 + 8'd1 : b1;
        // roman numeral one maps onto its jis x 0208 look-alike
        if (a2 == CIRC_HIGH && b2 == CIRC_LOW) begin
            sjis_high = ALT_HIGH;
            sjis_low  = ALT_LOW;
        end else begin
            sjis_high = a2;
            sjis_low  = b2;
        end
    end

endmodule

// ===== rtl/ets_ctrl.sv =====
// ets_ctrl: record state and per-cycle step decision for the held word
// depends on ets_pkg and ets_conv
module ets_ctrl #(
    parameter int MAX_CHARS    = 16,
    parameter int RECORD_PAIRS = 17,
    parameter int PCW          = $clog2(RECORD_PAIRS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  ets_pkg::item_t   item,
    input  logic             out_free,
    output ets_pkg::step_t   step,
    output logic [PCW-1:0]   pair_cnt
);
    import ets_pkg::*;

    localparam int LIM = (MAX_CHARS < RECORD_PAIRS) ? MAX_CHARS : RECORD_PAIRS;
    localparam logic [PCW-1:0] LIM_W  = PCW'(LIM);
    localparam logic [PCW-1:0] REC_W  = PCW'(RECORD_PAIRS);
    localparam logic [PCW-1:0] LAST_W = PCW'(RECORD_PAIRS - 1);

    logic [PCW-1:0] pc_reg, pc_next;
    logic main_flag_reg, main_flag_next;
    logic main_ended_reg, main_ended_next;
    logic sub_started_reg, sub_started_next;
    logic sub_ended_reg, sub_ended_next;

    logic [7:0] conv_high;
    logic [7:0] conv_low;
    logic       room;
    logic       clr;

    ets_conv u_conv (
        .euc_high  (item.code_high),
        .euc_low   (item.code_low),
        .sjis_high (conv_high),
        .sjis_low  (conv_low)
    );

    assign room     = pc_reg < LIM_W;
    assign pair_cnt = pc_reg;

    always_comb begin
        main_flag_next   = main_flag_reg;
        main_ended_next  = main_ended_reg;
        sub_started_next = sub_started_reg;
        sub_ended_next   = sub_ended_reg;
        clr              = 1'b0;
        step.emit        = 1'b0;
        step.done        = 1'b1;
        step.out_high    = conv_high;
        step.out_low     = conv_low;
        step.last        = 1'b0;
        step.slot        = 5'(pc_reg);
        unique case (item.func)
            FN_START: begin
                clr = 1'b1;
            end
            FN_MAIN: begin
                if (main_flag_reg && !main_ended_reg && !sub_started_reg) begin
                    if (item.code_high == 8'd0) begin
                        main_ended_next = 1'b1;
                    end else if (room) begin
                        step.emit = 1'b1;
                    end
                end
            end
            FN_SUB: begin
                main_ended_next = 1'b1;
                if (!sub_ended_reg) begin
                    if (item.code_high == 8'd0) begin
                        sub_started_next = 1'b1;
                        sub_ended_next   = 1'b1;
                    end else if (!sub_started_reg && main_flag_reg && room) begin
                        // separator first; the character is tried on the word's next step
                        sub_started_next = 1'b1;
                        step.emit        = 1'b1;
                        step.done        = 1'b0;
                        step.out_high    = DOT_HIGH;
                        step.out_low     = DOT_LOW;
                    end else begin
                        sub_started_next = 1'b1;
                        step.emit        = room;
                    end
                end
            end
            FN_FIN: begin
                step.out_high = 8'd0;
                step.out_low  = 8'd0;
                if (pc_reg < REC_W) begin
                    step.emit = 1'b1;
                    step.last = (pc_reg == LAST_W);
                    step.done = step.last;
                    clr       = step.last;
                end else begin
                    clr = 1'b1;
                end
            end
            default: begin
                clr = 1'b1;
            end
        endcase
        step.fire = item_valid && (!step.emit || out_free);

        pc_next = step.emit ? pc_reg + PCW'(1) : pc_reg;
        if (clr) begin
            pc_next          = '0;
            main_flag_next   = (item.func == FN_START) ? item.main_present : 1'b0;
            main_ended_next  = 1'b0;
            sub_started_next = 1'b0;
            sub_ended_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= '0;
            main_flag_reg   <= 1'b0;
            main_ended_reg  <= 1'b0;
            sub_started_reg <= 1'b0;
            sub_ended_reg   <= 1'b0;
        end else if (step.fire) begin
            pc_reg          <= pc_next;
            main_flag_reg   <= main_flag_next;
            main_ended_reg  <= main_ended_next;
            sub_started_reg <= sub_started_next;
            sub_ended_reg   <= sub_ended_next;
        end
    end

endmodule
